// ===== rtl/irms_pkg.sv =====
`timescale 1ns / 1ps
package irms_pkg;

   // default sizing
   localparam int MaxPixelsDefault  = 4194304;
   localparam int SampleBitsDefault = 8;

   // fixed field widths
   localparam int SampleW    = 8;
   localparam int DimW       = 13;
   localparam int CsrDataW   = 13;
   localparam int CsrIndexW  = 3;
   localparam int RmsW       = 17;
   localparam int QuoW       = 34;
   localparam int RootSteps  = 17;
   localparam int RootCntW   = 5;

   localparam logic [RmsW-1:0] RmsOne = 17'h10000;

   typedef enum logic [CsrIndexW-1:0] {
      REG_MAX_A    = 3'd0,
      REG_MAX_B    = 3'd1,
      REG_WIDTH_A  = 3'd2,
      REG_HEIGHT_A = 3'd3,
      REG_WIDTH_B  = 3'd4,
      REG_HEIGHT_B = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic load_pixel;
      logic products;
      logic squares;
      logic accumulate;
      logic den_prod;
      logic den_square;
      logic den_count;
      logic den_final;
      logic div_step;
      logic root_init;
      logic root_step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic last_pixel;
      logic size_error;
   } dp_status_type;

endpackage

// ===== rtl/irms_if.sv =====
`timescale 1ns / 1ps
interface irms_req_if import irms_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SampleW-1:0] red_a;
   logic [SampleW-1:0] green_a;
   logic [SampleW-1:0] blue_a;
   logic [SampleW-1:0] red_b;
   logic [SampleW-1:0] green_b;
   logic [SampleW-1:0] blue_b;
   logic               last_pixel;

   modport source (output valid, red_a, green_a, blue_a, red_b, green_b, blue_b,
                   last_pixel, input ready);
   modport sink (input valid, red_a, green_a, blue_a, red_b, green_b, blue_b,
                 last_pixel, output ready);
endinterface

interface irms_rsp_if import irms_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [RmsW-1:0] rms_error;
   logic            status;

   modport source (output valid, rms_error, status, input ready);
   modport sink (input valid, rms_error, status, output ready);
endinterface

// ===== rtl/irms_datapath.sv =====
`timescale 1ns / 1ps
module irms_datapath import irms_pkg::*; #(
   parameter int MAX_PIXELS  = MaxPixelsDefault,
   parameter int SAMPLE_BITS = SampleBitsDefault,
   parameter int CNT_W       = $clog2(MAX_PIXELS + 1),
   parameter int SUM_W       = 34 + CNT_W,
   parameter int DIVD_W      = SUM_W + 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic [SampleW-1:0]   red_a,
   input  logic [SampleW-1:0]   green_a,
   input  logic [SampleW-1:0]   blue_a,
   input  logic [SampleW-1:0]   red_b,
   input  logic [SampleW-1:0]   green_b,
   input  logic [SampleW-1:0]   blue_b,
   input  logic                 last_pixel,
   input  logic                 csr_write_en,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data,
   output logic [RmsW-1:0]      rms_error,
   output logic                 rms_status
);

   localparam int P3W  = 32 + CNT_W;
   localparam int DENW = P3W + 2;
   localparam logic [SampleW-1:0] SampleMask = SampleW'((1 << SAMPLE_BITS) - 1);
   localparam logic [CNT_W-1:0]   CntLimit   = CNT_W'(MAX_PIXELS);
   localparam logic [QuoW-1:0]    QuoLimit   = QuoW'(64'h1_0000_0000);

   // configuration
   logic [SampleW-1:0] max_a_ff, max_b_ff;
   logic [DimW-1:0]    width_a_ff, height_a_ff, width_b_ff, height_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_a_ff    <= 8'hFF & SampleMask;
         max_b_ff    <= 8'hFF & SampleMask;
         width_a_ff  <= '0;
         height_a_ff <= '0;
         width_b_ff  <= '0;
         height_b_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            REG_MAX_A:    max_a_ff    <= csr_data[SampleW-1:0] & SampleMask;
            REG_MAX_B:    max_b_ff    <= csr_data[SampleW-1:0] & SampleMask;
            REG_WIDTH_A:  width_a_ff  <= csr_data;
            REG_HEIGHT_A: height_a_ff <= csr_data;
            REG_WIDTH_B:  width_b_ff  <= csr_data;
            REG_HEIGHT_B: height_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // size check
   logic [DimW-1:0] dw, dh;
   always_comb begin
      dw = (width_a_ff >= width_b_ff) ? width_a_ff - width_b_ff : width_b_ff - width_a_ff;
      dh = (height_a_ff >= height_b_ff) ? height_a_ff - height_b_ff
                                        : height_b_ff - height_a_ff;
   end

   // pixel stages
   logic [SampleW-1:0] a_ff [3];
   logic [SampleW-1:0] b_ff [3];
   logic               last_ff;
   logic [15:0]        diff_ff [3];
   logic [31:0]        sq_ff [3];
   logic [15:0]        x_prod [3];
   logic [15:0]        y_prod [3];

   assign status.last_pixel = last_ff;
   assign status.size_error = (dw > 13'd1) || (dh > 13'd1);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         x_prod[i] = a_ff[i] * max_b_ff;
         y_prod[i] = b_ff[i] * max_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         a_ff[0] <= red_a & SampleMask;
         a_ff[1] <= green_a & SampleMask;
         a_ff[2] <= blue_a & SampleMask;
         b_ff[0] <= red_b & SampleMask;
         b_ff[1] <= green_b & SampleMask;
         b_ff[2] <= blue_b & SampleMask;
         last_ff <= last_pixel;
      end
      if (cmd.products) begin
         for (int i = 0; i < 3; i++) begin
            diff_ff[i] <= (x_prod[i] >= y_prod[i]) ? x_prod[i] - y_prod[i]
                                                   : y_prod[i] - x_prod[i];
         end
      end
      if (cmd.squares) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= diff_ff[i] * diff_ff[i];
         end
      end
   end

   // running sum and count
   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [33:0]      add_val;

   assign add_val = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.accumulate && cnt_ff < CntLimit) begin
         sum_ff <= sum_ff + SUM_W'(add_val);
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // denominator: 3 * count * max_a^2 * max_b^2
   logic [15:0]     p1_ff;
   logic [31:0]     p2_ff;
   logic [P3W-1:0]  p3_ff;
   logic [DENW-1:0] den_ff;

   always_ff @(posedge clock) begin
      if (cmd.den_prod)   p1_ff  <= max_a_ff * max_b_ff;
      if (cmd.den_square) p2_ff  <= p1_ff * p1_ff;
      if (cmd.den_count)  p3_ff  <= p2_ff * cnt_ff;
      if (cmd.den_final)  den_ff <= {1'b0, p3_ff, 1'b0} + {2'b00, p3_ff};
   end

   // restoring division of sum * 2^32, one quotient bit a cycle
   logic [DIVD_W-1:0] divd_ff;
   logic [DENW:0]     rem_ff;
   logic [QuoW-1:0]   quo_ff;
   logic              ovf_ff;
   logic [DENW:0]     rem_sh;
   logic              rem_ge;

   always_comb begin
      rem_sh = {rem_ff[DENW-1:0], divd_ff[DIVD_W-1]};
      rem_ge = rem_sh >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.den_final) begin
         divd_ff <= {sum_ff, 32'd0};
         rem_ff  <= '0;
         quo_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (cmd.div_step) begin
         divd_ff <= {divd_ff[DIVD_W-2:0], 1'b0};
         rem_ff  <= rem_ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_ff  <= {quo_ff[QuoW-2:0], rem_ge};
         ovf_ff  <= ovf_ff | quo_ff[QuoW-1];
      end
   end

   // integer square root, one result bit a cycle
   logic [QuoW-1:0] rv_ff, rr_ff, rbit_ff;
   logic [QuoW-1:0] r_trial;

   assign r_trial = rr_ff + rbit_ff;

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         rv_ff   <= quo_ff;
         rr_ff   <= '0;
         rbit_ff <= QuoLimit;
      end else if (cmd.root_step) begin
         if (rv_ff >= r_trial) begin
            rv_ff <= rv_ff - r_trial;
            rr_ff <= (rr_ff >> 1) + rbit_ff;
         end else begin
            rr_ff <= rr_ff >> 1;
         end
         rbit_ff <= rbit_ff >> 2;
      end
   end

   // result register
   logic [RmsW-1:0] rms_ff;
   logic            stat_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (status.size_error) begin
            rms_ff  <= RmsOne;
            stat_ff <= 1'b1;
         end else begin
            stat_ff <= 1'b0;
            if (den_ff == '0) begin
               rms_ff <= '0;
            end else if (ovf_ff || quo_ff > QuoLimit) begin
               rms_ff <= RmsOne;
            end else if (rr_ff > QuoW'(RmsOne)) begin
               rms_ff <= RmsOne;
            end else begin
               rms_ff <= rr_ff[RmsW-1:0];
            end
         end
      end
   end

   assign rms_error  = rms_ff;
   assign rms_status = stat_ff;

endmodule

// ===== rtl/irms_ctrl.sv =====
`timescale 1ns / 1ps
module irms_ctrl import irms_pkg::*; #(
   parameter int DIV_STEPS = 89
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int DivCntW = $clog2(DIV_STEPS);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_PROD   = 12'b000000000010,
      S_SQR    = 12'b000000000100,
      S_ACC    = 12'b000000001000,
      S_DEN1   = 12'b000000010000,
      S_DEN2   = 12'b000000100000,
      S_DEN3   = 12'b000001000000,
      S_DEN4   = 12'b000010000000,
      S_DIV    = 12'b000100000000,
      S_RINIT  = 12'b001000000000,
      S_ROOT   = 12'b010000000000,
      S_FINISH = 12'b100000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [DivCntW-1:0]   div_cnt_ff, div_cnt_in;
   logic [RootCntW-1:0]  root_cnt_ff, root_cnt_in;
   logic                 out_valid_ff, out_valid_in;

   // sequence one pixel; on the last one, build the denominator, divide and root unless the sizes mismatch
   always_comb begin
      state_in    = state_ff;
      div_cnt_in  = div_cnt_ff;
      root_cnt_in = root_cnt_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_pixel = 1'b1;
               state_in       = S_PROD;
            end
         end
         S_PROD: begin
            cmd.products = 1'b1;
            state_in     = S_SQR;
         end
         S_SQR: begin
            cmd.squares = 1'b1;
            state_in    = S_ACC;
         end
         S_ACC: begin
            cmd.accumulate = 1'b1;
            if (!status.last_pixel) state_in = S_IDLE;
            else if (status.size_error) state_in = S_FINISH;
            else state_in = S_DEN1;
         end
         S_DEN1: begin
            cmd.den_prod = 1'b1;
            state_in     = S_DEN2;
         end
         S_DEN2: begin
            cmd.den_square = 1'b1;
            state_in       = S_DEN3;
         end
         S_DEN3: begin
            cmd.den_count = 1'b1;
            state_in      = S_DEN4;
         end
         S_DEN4: begin
            cmd.den_final = 1'b1;
            div_cnt_in    = DivCntW'(DIV_STEPS - 1);
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff - DivCntW'(1);
            if (div_cnt_ff == '0) state_in = S_RINIT;
         end
         S_RINIT: begin
            cmd.root_init = 1'b1;
            root_cnt_in   = RootCntW'(RootSteps - 1);
            state_in      = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            root_cnt_in   = root_cnt_ff - RootCntW'(1);
            if (root_cnt_ff == '0) state_in = S_FINISH;
         end
         S_FINISH: begin
            // wait for the output register to free up
            if (!out_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign out_valid_in = cmd.finish | (out_valid_ff & ~rsp_ready);
   assign rsp_valid    = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= '0;
         root_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         root_cnt_ff  <= root_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_rise_after_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result appeared without a finish step");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_PROD)
      else $error("accepted beat did not start the pixel sequence");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_cnt_ff == '0) |=> state_ff == S_RINIT)
      else $error("divide did not end on its last step");

   a_root_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT && root_cnt_ff == '0) |=> state_ff == S_FINISH)
      else $error("root did not end on its last step");

endmodule

// ===== rtl/image_rms_difference.sv =====
`timescale 1ns / 1ps
// RMS difference of two RGB images. Each pixel-pair beat is latched and then
// runs channel products, squares and accumulate; ready is high only while the
// block waits for a beat. The beat marked last_pixel additionally runs a
// denominator build, a bit-serial restoring divide of sum * 2^32 (one
// dividend bit per cycle, 89 bits at the default MAX_PIXELS), a bit-serial
// square root and a load of the result register. A size mismatch skips the
// denominator, divide and root. The result register lets the next image
// start while a result still waits to be taken.
module image_rms_difference import irms_pkg::*; #(
   parameter int MAX_PIXELS  = MaxPixelsDefault,
   parameter int SAMPLE_BITS = SampleBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   irms_req_if.sink             req_chan,
   irms_rsp_if.source           rsp_chan,
   input  logic                 csr_write_en,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data
);

   localparam int CntW  = $clog2(MAX_PIXELS + 1);
   localparam int SumW  = 34 + CntW;
   localparam int DivdW = SumW + 32;

   dp_cmd_type    cmd;
   dp_status_type status;

   irms_ctrl #(
      .DIV_STEPS (DivdW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   irms_datapath #(
      .MAX_PIXELS  (MAX_PIXELS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CntW),
      .SUM_W       (SumW),
      .DIVD_W      (DivdW)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .red_a        (req_chan.red_a),
      .green_a      (req_chan.green_a),
      .blue_a       (req_chan.blue_a),
      .red_b        (req_chan.red_b),
      .green_b      (req_chan.green_b),
      .blue_b       (req_chan.blue_b),
      .last_pixel   (req_chan.last_pixel),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rms_error    (rsp_chan.rms_error),
      .rms_status   (rsp_chan.status)
   );

endmodule
